>>> rtl/rrtt_pkg.sv
// Shared types, constants and helpers for the round-robin task table.
package rrtt_pkg;

	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [31:0] FIRST_PID_RESET = 32'd1000;

	typedef enum logic [2:0] {
		ACT_SWITCH  = 3'd0,
		ACT_FSWITCH = 3'd1,
		ACT_CREATE  = 3'd2,
		ACT_START   = 3'd3,
		ACT_PAUSE   = 3'd4,
		ACT_RESUME  = 3'd5,
		ACT_KILL    = 3'd6,
		ACT_QUERY   = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		SLOT_ABSENT  = 2'd0,
		SLOT_NEW     = 2'd1,
		SLOT_RUNNING = 2'd2,
		SLOT_PAUSED  = 2'd3
	} slot_st_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SW,
		ST_SW_FIN,
		ST_FREE,
		ST_LOAD,
		ST_FIND,
		ST_K_CLOSE,
		ST_K_REMOVE,
		ST_K_PAR,
		ST_K_CHILD,
		ST_K_FIN,
		ST_DONE,
		ST_OUT
	} fsm_t;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
		wrap_inc = (idx == IDX_W'(SLOTS - 1)) ? '0 : idx + 1'b1;
	endfunction

endpackage

>>> rtl/round_robin_task_table.sv
// Round-robin task table: slot store, scan sequencer and result register.
//
// Each transaction is handled by a sequencer that visits one slot per
// cycle. Switch, create, start, pause and resume make at most one scan of
// the 16 slots before the result is built; query goes straight to the
// result. Kill finds the task, then builds the set of descendants with one
// parent compare per cycle in passes over every pair of slots, repeated
// until a pass adds nothing, then scans for the parent and its children
// and may end with a forced switch. The input is not ready while a
// transaction is in work or its result waits. Writing first_pid reloads
// the next task id.
module round_robin_task_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action[2:0], task_id[34:3], program_handle[50:35]
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// ok[0], current_slot[4:1], current_pid[36:5], current_program[52:37],
	// new_pid[84:53], needs_start[85], return_to_root[86]
	output logic [87:0] m_tdata,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int IW = rrtt_pkg::IDX_W;
	localparam int CW = rrtt_pkg::CNT_W;
	localparam int N  = rrtt_pkg::SLOTS;

	rrtt_pkg::fsm_t state_q, state_d;
	rrtt_pkg::slot_st_t status_q [N];
	logic [31:0] pid_q [N];
	logic [31:0] par_q [N];
	logic [15:0] pgm_q [N];
	logic [N-1:0] mark_q;

	rrtt_pkg::act_t act_q;
	logic [31:0] id_q, next_id_q, kparent_q, newpid_q;
	logic [15:0] prog_q;
	logic [IW-1:0] cur_q, start_cur_q, sp_q, k_q, j_q, fidx_q;
	logic [CW-1:0] live_q;
	logic forced_q, ok_q, needs_q, root_q, changed_q, found_q, child_q;
	logic [87:0] out_q;

	logic accept, sp_last, j_last, sw_hit, live_hit, close_hit, child_hit, cur_live;
	logic [IW-1:0] cur_fin;
	logic [31:0] give_id;
	logic [N-1:0] live_vec;

	assign accept   = s_tvalid && s_tready;
	assign sp_last  = (sp_q == IW'(N - 1));
	assign j_last   = (j_q == IW'(N - 1));
	assign cur_live = (status_q[cur_q] != rrtt_pkg::SLOT_ABSENT);
	assign give_id  = (next_id_q == '0) ? 32'd1 : next_id_q;
	assign sw_hit   = (status_q[sp_q] == rrtt_pkg::SLOT_RUNNING) ||
		(!forced_q && status_q[sp_q] == rrtt_pkg::SLOT_NEW);
	assign live_hit = (status_q[sp_q] != rrtt_pkg::SLOT_ABSENT) &&
		(pid_q[sp_q] == ((state_q == rrtt_pkg::ST_K_PAR) ? kparent_q : id_q));
	assign close_hit = !mark_q[j_q] && (status_q[j_q] != rrtt_pkg::SLOT_ABSENT) &&
		mark_q[sp_q] && (pid_q[sp_q] == par_q[j_q]);
	assign child_hit = (status_q[sp_q] != rrtt_pkg::SLOT_ABSENT) &&
		(par_q[sp_q] == kparent_q);
	// Current slot once the parent of a killed task has been resumed.
	assign cur_fin = (found_q && !child_q) ? fidx_q : cur_q;

	always_comb begin
		for (int i = 0; i < N; i++) begin
			live_vec[i] = (status_q[i] != rrtt_pkg::SLOT_ABSENT);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrtt_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (rrtt_pkg::act_t'(s_tdata[2:0])) inside
						rrtt_pkg::ACT_SWITCH, rrtt_pkg::ACT_FSWITCH:
							state_d = (live_q <= CW'(1)) ? rrtt_pkg::ST_DONE : rrtt_pkg::ST_SW;
						rrtt_pkg::ACT_CREATE, rrtt_pkg::ACT_START: state_d = rrtt_pkg::ST_FREE;
						rrtt_pkg::ACT_PAUSE, rrtt_pkg::ACT_RESUME, rrtt_pkg::ACT_KILL:
							state_d = rrtt_pkg::ST_FIND;
						default: state_d = rrtt_pkg::ST_DONE;
					endcase
				end
			end
			rrtt_pkg::ST_SW: begin
				if (sw_hit || k_q == IW'(N - 1)) state_d = rrtt_pkg::ST_SW_FIN;
			end
			rrtt_pkg::ST_SW_FIN: state_d = rrtt_pkg::ST_DONE;
			rrtt_pkg::ST_FREE: begin
				if (status_q[sp_q] == rrtt_pkg::SLOT_ABSENT) state_d = rrtt_pkg::ST_LOAD;
				else if (sp_last) state_d = rrtt_pkg::ST_DONE;
			end
			rrtt_pkg::ST_LOAD: state_d = rrtt_pkg::ST_DONE;
			rrtt_pkg::ST_FIND: begin
				if (live_hit) begin
					state_d = (act_q == rrtt_pkg::ACT_KILL) ? rrtt_pkg::ST_K_CLOSE
						: rrtt_pkg::ST_DONE;
				end else if (sp_last) begin
					state_d = rrtt_pkg::ST_DONE;
				end
			end
			rrtt_pkg::ST_K_CLOSE: begin
				if (sp_last && j_last && !(changed_q || close_hit))
					state_d = rrtt_pkg::ST_K_REMOVE;
			end
			rrtt_pkg::ST_K_REMOVE:
				state_d = (kparent_q == '0) ? rrtt_pkg::ST_DONE : rrtt_pkg::ST_K_PAR;
			rrtt_pkg::ST_K_PAR: begin
				if (live_hit) state_d = rrtt_pkg::ST_K_CHILD;
				else if (sp_last) state_d = rrtt_pkg::ST_K_FIN;
			end
			rrtt_pkg::ST_K_CHILD: begin
				if (child_hit || sp_last) state_d = rrtt_pkg::ST_K_FIN;
			end
			rrtt_pkg::ST_K_FIN: begin
				if (mark_q[start_cur_q] && live_q > CW'(1)) state_d = rrtt_pkg::ST_SW;
				else state_d = rrtt_pkg::ST_DONE;
			end
			rrtt_pkg::ST_DONE: state_d = rrtt_pkg::ST_OUT;
			rrtt_pkg::ST_OUT: begin
				if (m_tready) state_d = rrtt_pkg::ST_IDLE;
			end
			default: state_d = rrtt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == rrtt_pkg::ST_IDLE);
		m_tvalid = (state_q == rrtt_pkg::ST_OUT);
		m_tdata  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrtt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: slot status, current slot, live count and id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) status_q[i] <= rrtt_pkg::SLOT_ABSENT;
			cur_q     <= '0;
			live_q    <= '0;
			next_id_q <= rrtt_pkg::FIRST_PID_RESET;
		end else begin
			if (cfg_we) next_id_q <= cfg_wdata;
			case (state_q)
				rrtt_pkg::ST_IDLE: begin
					if (accept && rrtt_pkg::act_t'(s_tdata[2:0]) == rrtt_pkg::ACT_START && cur_live)
						status_q[cur_q] <= rrtt_pkg::SLOT_PAUSED;
				end
				rrtt_pkg::ST_SW: begin
					if (sw_hit) cur_q <= sp_q;
				end
				rrtt_pkg::ST_SW_FIN: begin
					if (status_q[cur_q] == rrtt_pkg::SLOT_NEW)
						status_q[cur_q] <= rrtt_pkg::SLOT_RUNNING;
				end
				rrtt_pkg::ST_LOAD: begin
					next_id_q <= give_id + 32'd1;
					live_q    <= live_q + 1'b1;
					if (act_q == rrtt_pkg::ACT_START) begin
						status_q[fidx_q] <= rrtt_pkg::SLOT_RUNNING;
						cur_q            <= fidx_q;
					end else begin
						status_q[fidx_q] <= rrtt_pkg::SLOT_NEW;
					end
				end
				rrtt_pkg::ST_FIND: begin
					if (live_hit && act_q == rrtt_pkg::ACT_PAUSE)
						status_q[sp_q] <= rrtt_pkg::SLOT_PAUSED;
					if (live_hit && act_q == rrtt_pkg::ACT_RESUME)
						status_q[sp_q] <= rrtt_pkg::SLOT_RUNNING;
				end
				rrtt_pkg::ST_K_REMOVE: begin
					for (int i = 0; i < N; i++) begin
						if (mark_q[i]) status_q[i] <= rrtt_pkg::SLOT_ABSENT;
					end
					live_q <= live_q - CW'($countones(mark_q));
				end
				rrtt_pkg::ST_K_FIN: begin
					if (found_q && !child_q) begin
						status_q[fidx_q] <= rrtt_pkg::SLOT_RUNNING;
						cur_q            <= fidx_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Scan pointers, transaction fields, slot payload and result.
	always_ff @(posedge clk) begin
		case (state_q)
			rrtt_pkg::ST_IDLE: begin
				if (accept) begin
					act_q       <= rrtt_pkg::act_t'(s_tdata[2:0]);
					id_q        <= s_tdata[34:3];
					prog_q      <= s_tdata[50:35];
					start_cur_q <= cur_q;
					forced_q    <= (rrtt_pkg::act_t'(s_tdata[2:0]) == rrtt_pkg::ACT_FSWITCH);
					ok_q        <= 1'b1;
					needs_q     <= 1'b0;
					root_q      <= 1'b0;
					newpid_q    <= '0;
					found_q     <= 1'b0;
					child_q     <= 1'b0;
					mark_q      <= '0;
					k_q         <= IW'(1);
					sp_q        <= (rrtt_pkg::act_t'(s_tdata[2:0]) == rrtt_pkg::ACT_SWITCH ||
						rrtt_pkg::act_t'(s_tdata[2:0]) == rrtt_pkg::ACT_FSWITCH)
						? rrtt_pkg::wrap_inc(cur_q) : '0;
				end
			end
			rrtt_pkg::ST_SW: begin
				sp_q <= rrtt_pkg::wrap_inc(sp_q);
				k_q  <= k_q + 1'b1;
			end
			rrtt_pkg::ST_SW_FIN: begin
				if (status_q[cur_q] == rrtt_pkg::SLOT_NEW) needs_q <= 1'b1;
			end
			rrtt_pkg::ST_FREE: begin
				if (status_q[sp_q] == rrtt_pkg::SLOT_ABSENT) fidx_q <= sp_q;
				else if (sp_last) ok_q <= 1'b0;
				sp_q <= rrtt_pkg::wrap_inc(sp_q);
			end
			rrtt_pkg::ST_LOAD: begin
				pid_q[fidx_q] <= give_id;
				par_q[fidx_q] <= cur_live ? pid_q[cur_q] : '0;
				pgm_q[fidx_q] <= prog_q;
				newpid_q      <= give_id;
				if (act_q == rrtt_pkg::ACT_START) needs_q <= 1'b1;
			end
			rrtt_pkg::ST_FIND: begin
				if (live_hit) begin
					kparent_q    <= par_q[sp_q];
					mark_q[sp_q] <= 1'b1;
					changed_q    <= 1'b0;
					j_q          <= '0;
					sp_q         <= '0;
				end else begin
					if (sp_last) ok_q <= 1'b0;
					sp_q <= rrtt_pkg::wrap_inc(sp_q);
				end
			end
			rrtt_pkg::ST_K_CLOSE: begin
				// One descendant compare per cycle: parent of slot j against id of slot sp.
				if (close_hit) begin
					mark_q[j_q] <= 1'b1;
					changed_q   <= 1'b1;
				end
				sp_q <= rrtt_pkg::wrap_inc(sp_q);
				if (sp_last) begin
					j_q <= rrtt_pkg::wrap_inc(j_q);
					if (j_last) changed_q <= 1'b0;
				end
			end
			rrtt_pkg::ST_K_REMOVE: begin
				if (kparent_q == '0) root_q <= 1'b1;
				sp_q <= '0;
			end
			rrtt_pkg::ST_K_PAR: begin
				if (live_hit) begin
					fidx_q  <= sp_q;
					found_q <= 1'b1;
					sp_q    <= '0;
				end else begin
					sp_q <= rrtt_pkg::wrap_inc(sp_q);
				end
			end
			rrtt_pkg::ST_K_CHILD: begin
				if (child_hit) child_q <= 1'b1;
				sp_q <= rrtt_pkg::wrap_inc(sp_q);
			end
			rrtt_pkg::ST_K_FIN: begin
				forced_q <= 1'b1;
				sp_q     <= rrtt_pkg::wrap_inc(cur_fin);
				k_q      <= IW'(1);
			end
			rrtt_pkg::ST_DONE: begin
				out_q <= {1'b0, root_q, needs_q, newpid_q,
					cur_live ? pgm_q[cur_q] : 16'd0,
					cur_live ? pid_q[cur_q] : 32'd0,
					4'(cur_q), ok_q};
			end
			default: ;
		endcase
	end

	a_live_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrtt_pkg::ST_IDLE) |-> (CW'($countones(live_vec)) == live_q))
		else $error("live count disagrees with slot status");

	a_back_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready) |=> s_tready)
		else $error("sequencer did not return to idle after the result transaction");

	a_new_id_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrtt_pkg::ST_LOAD) |=> (newpid_q != '0))
		else $error("a created task received id zero");

	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rrtt_pkg::ST_DONE) |-> (32'(cur_q) < 32'(N)))
		else $error("current slot out of range");

endmodule
